[rtl/hpplg_pkg.sv]
// Package with the slot codes, register indexes and item types of the HPP lattice-gas SIR cell update.
`timescale 1ns / 1ps
`default_nettype none

package hpplg_pkg;

  localparam int SLOT_W = 2;
  localparam int THR_W = 9;
  localparam int DRAW_W = 64;
  localparam int CFG_INDEX_W = 1;

  localparam logic [SLOT_W-1:0] SLOT_EMPTY = 2'd0;
  localparam logic [SLOT_W-1:0] SLOT_SUSC = 2'd1;
  localparam logic [SLOT_W-1:0] SLOT_INF = 2'd2;
  localparam logic [SLOT_W-1:0] SLOT_REC = 2'd3;

  localparam logic [CFG_INDEX_W-1:0] REG_INFECTION_THRESHOLD = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_RECOVERY_THRESHOLD = 1'd1;

  localparam logic [THR_W-1:0] INFECTION_THRESHOLD_RESET = 9'd154;
  localparam logic [THR_W-1:0] RECOVERY_THRESHOLD_RESET = 9'd51;

  typedef struct packed {
    logic [SLOT_W-1:0] arriving_southward;
    logic [SLOT_W-1:0] arriving_eastward;
    logic [SLOT_W-1:0] arriving_westward;
    logic [SLOT_W-1:0] arriving_northward;
    logic [SLOT_W-1:0] current_north;
    logic [SLOT_W-1:0] current_east;
    logic [SLOT_W-1:0] current_west;
    logic [SLOT_W-1:0] current_south;
    logic [DRAW_W-1:0] random_draws;
  } site_t;

  typedef struct packed {
    logic [SLOT_W-1:0] next_north;
    logic [SLOT_W-1:0] next_east;
    logic [SLOT_W-1:0] next_west;
    logic [SLOT_W-1:0] next_south;
    logic changed;
  } result_t;

endpackage

`default_nettype wire

[rtl/hpplg_if.sv]
// Valid/ready channel interfaces for site items and result items.
`timescale 1ns / 1ps
`default_nettype none

interface hpplg_site_if;
  logic valid;
  logic ready;
  hpplg_pkg::site_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface hpplg_result_if;
  logic valid;
  logic ready;
  hpplg_pkg::result_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

[rtl/hpp_lattice_gas_sir_cell_update_unit.sv]
// Top level of the HPP lattice-gas SIR cell update: input register, site rule, result register.
//
// Channel  Direction  Handshake    Payload
// site     in         valid/ready  four arriving slots, four current slots, 64-bit draws
// result   out        valid/ready  four next slots, changed flag
// cfg      in         cfg_we only  cfg_index selects threshold, cfg_data is 9 bits
//
// Each item passes through the input register and then the result register, and one item can
// be accepted every cycle while the result is not stalled.
// The rule itself is combinational logic of slot muxes and byte compares between the two registers.
// Reset clears both valid flags and loads the default thresholds.
// A stalled result holds its register, and the input register moves up whenever it frees.
`timescale 1ns / 1ps
`default_nettype none

module hpp_lattice_gas_sir_cell_update_unit (
  input  wire logic clk,
  input  wire logic rst,
  hpplg_site_if.sink site,
  hpplg_result_if.source result,
  input  wire logic cfg_we,
  input  wire logic [hpplg_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [hpplg_pkg::THR_W-1:0] cfg_data
);

  logic [hpplg_pkg::THR_W-1:0] infection_threshold;
  logic [hpplg_pkg::THR_W-1:0] recovery_threshold;

  logic stage_valid;
  hpplg_pkg::site_t stage;
  logic out_valid;
  hpplg_pkg::result_t out_data;

  logic out_free;
  logic stage_free;
  hpplg_pkg::result_t result_next;

  logic [hpplg_pkg::SLOT_W-1:0] v_col [4];
  logic [hpplg_pkg::SLOT_W-1:0] v_inf [4];
  logic [hpplg_pkg::SLOT_W-1:0] v_rec [4];
  logic [7:0] inf_draw [4];
  logic [7:0] rec_draw [4];
  logic any_inf;

  assign out_free = !out_valid || result.ready;
  assign stage_free = !stage_valid || out_free;
  assign site.ready = stage_free;
  assign result.valid = out_valid;
  assign result.payload = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      infection_threshold <= hpplg_pkg::INFECTION_THRESHOLD_RESET;
      recovery_threshold <= hpplg_pkg::RECOVERY_THRESHOLD_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        hpplg_pkg::REG_INFECTION_THRESHOLD: infection_threshold <= cfg_data;
        hpplg_pkg::REG_RECOVERY_THRESHOLD: recovery_threshold <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (stage_free) begin
        stage_valid <= site.valid;
      end
      if (out_free) begin
        out_valid <= stage_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (stage_free && site.valid) begin
      stage <= site.payload;
    end
    if (out_free && stage_valid) begin
      out_data <= result_next;
    end
  end

  // Slot order inside the rule is north, west, east, south, matching the draw bytes.
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      inf_draw[k] = stage.random_draws[8*k +: 8];
      rec_draw[k] = stage.random_draws[8*(k+4) +: 8];
    end

    v_col[0] = stage.arriving_northward;
    v_col[1] = stage.arriving_westward;
    v_col[2] = stage.arriving_eastward;
    v_col[3] = stage.arriving_southward;
    if ((stage.arriving_westward != hpplg_pkg::SLOT_EMPTY)
        && (stage.arriving_eastward != hpplg_pkg::SLOT_EMPTY)
        && (stage.arriving_northward == hpplg_pkg::SLOT_EMPTY)
        && (stage.arriving_southward == hpplg_pkg::SLOT_EMPTY)) begin
      v_col[0] = stage.arriving_westward;
      v_col[3] = stage.arriving_eastward;
      v_col[1] = hpplg_pkg::SLOT_EMPTY;
      v_col[2] = hpplg_pkg::SLOT_EMPTY;
    end else if ((stage.arriving_northward != hpplg_pkg::SLOT_EMPTY)
        && (stage.arriving_southward != hpplg_pkg::SLOT_EMPTY)
        && (stage.arriving_westward == hpplg_pkg::SLOT_EMPTY)
        && (stage.arriving_eastward == hpplg_pkg::SLOT_EMPTY)) begin
      v_col[1] = stage.arriving_northward;
      v_col[2] = stage.arriving_southward;
      v_col[0] = hpplg_pkg::SLOT_EMPTY;
      v_col[3] = hpplg_pkg::SLOT_EMPTY;
    end

    any_inf = 1'b0;
    for (int k = 0; k < 4; k++) begin
      if (v_col[k] == hpplg_pkg::SLOT_INF) begin
        any_inf = 1'b1;
      end
    end

    for (int k = 0; k < 4; k++) begin
      v_inf[k] = v_col[k];
      if (any_inf && (v_col[k] == hpplg_pkg::SLOT_SUSC)
          && ({1'b0, inf_draw[k]} < infection_threshold)) begin
        v_inf[k] = hpplg_pkg::SLOT_INF;
      end
      v_rec[k] = v_inf[k];
      if ((v_inf[k] == hpplg_pkg::SLOT_INF) && ({1'b0, rec_draw[k]} < recovery_threshold)) begin
        v_rec[k] = hpplg_pkg::SLOT_REC;
      end
    end

    result_next.next_north = v_rec[0];
    result_next.next_west = v_rec[1];
    result_next.next_east = v_rec[2];
    result_next.next_south = v_rec[3];
    result_next.changed = (v_rec[0] != stage.current_north) || (v_rec[2] != stage.current_east)
        || (v_rec[1] != stage.current_west) || (v_rec[3] != stage.current_south);
  end

endmodule

`default_nettype wire
